// ----- hw/rtl/sldx_pkg.sv -----
// Shared types, constants and constant functions for the stereo-linked downward expander.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package sldx_pkg;

  localparam int SLDX_SAMPLE_BITS = 24;
  localparam int MUL_W            = 32;
  localparam int CFG_AW           = 5;
  localparam int CFG_DW           = 32;

  localparam int LEVEL_FLOOR_MAG  = 30720;   // -120 dB in Q8.8
  localparam int GAIN_FLOOR_MAG   = 23040;   // -90 dB in Q8.8
  localparam int DB_PER_LOG2      = 394566;  // 20*log10(2) in Q.16
  localparam int LOG2_PER_DB      = 2786635; // 1/(20*log10(2)) in Q.16 scaled for Q8.8 input

  localparam int LOG_STEPS        = 16;
  localparam int DIV_STEPS        = 17;
  localparam int EXP_STEPS        = 16;

  localparam logic signed [14:0] THRESHOLD_RST = -15'sd7680;
  localparam logic [11:0]        RATIO_RST     = 12'd512;
  localparam logic [15:0]        ATTACK_RST    = 16'd64185;
  localparam logic [15:0]        RELEASE_RST   = 16'd65522;
  localparam logic signed [15:0] FLOOR_RST     = -16'sd15360;
  localparam logic [12:0]        KNEE_RST      = 13'd1536;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_RATIO     = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_RELEASE   = 3'd3,
    REG_FLOOR     = 3'd4,
    REG_KNEE      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [14:0] threshold_db;
    logic [11:0]        expansion_ratio;
    logic [15:0]        attack_coeff;
    logic [15:0]        release_coeff;
    logic signed [15:0] range_floor_db;
    logic [12:0]        knee_width_db;
  } cfg_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_LOG,
    DP_LEVEL,
    DP_ENV,
    DP_GAIN,
    DP_NUM,
    DP_DIV,
    DP_CLAMP,
    DP_L2,
    DP_EXP,
    DP_SHIFT,
    DP_OUTL,
    DP_OUTR
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic knee_sel;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOG,
    ST_LEVEL,
    ST_ENV,
    ST_GAIN,
    ST_NUM,
    ST_DIV,
    ST_CLAMP,
    ST_L2,
    ST_EXP,
    ST_SHIFT,
    ST_OUTL,
    ST_OUTR
  } ctrl_state_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = 64'd0;
    bitv = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Q2.30 factor 2^(-2^(idx-16)), built by repeated square roots of 0.5
  function automatic logic [31:0] lin_coeff(input int idx);
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int k = 15; k >= 0; k--) begin
      if (k >= idx) begin
        c = isqrt64(c << 30);
      end
    end
    return c[31:0];
  endfunction

endpackage

// ----- hw/rtl/sldx_in_if.sv -----
// Input channel: one stereo pair per request, valid/ready handshake.
// Depends on sldx_pkg.
`timescale 1ns / 1ps
interface sldx_in_if
  import sldx_pkg::*;
#(
  parameter int SAMPLE_BITS = SLDX_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ----- hw/rtl/sldx_out_if.sv -----
// Result channel: scaled stereo pair plus applied gain, valid/ready handshake.
// Depends on sldx_pkg.
`timescale 1ns / 1ps
interface sldx_out_if
  import sldx_pkg::*;
#(
  parameter int SAMPLE_BITS = SLDX_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic signed [15:0]            gain_db;

  modport source (output valid, output left_out, output right_out, output gain_db, input ready);
  modport sink   (input valid, input left_out, input right_out, input gain_db, output ready);
endinterface

// ----- hw/rtl/sldx_dp.sv -----
// Datapath: shared 32x32 multiplier, log/exp iterations, envelope, knee divider, output regs.
// Depends on sldx_pkg; driven by sldx_ctrl commands.
`timescale 1ns / 1ps
module sldx_dp
  import sldx_pkg::*;
#(
  parameter int SAMPLE_BITS = SLDX_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd,
  input  cfg_t                          cfg,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  output dp_stat_t                      stat,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  output logic signed [15:0]            gain_db
);

  // Q2.30 factors for the fraction bits of -log2(gain)
  logic [31:0] c_tab [EXP_STEPS];
  for (genvar gi = 0; gi < EXP_STEPS; gi++) begin : g_ctab
    localparam logic [31:0] CVAL = lin_coeff(gi);
    assign c_tab[gi] = CVAL;
  end

  // sample capture
  logic                   l_neg_r, r_neg_r;
  logic [SAMPLE_BITS-1:0] al_r, ar_r;
  logic                   pk_zero_r;
  logic [4:0]             e_r;
  // level
  logic [31:0]            m_r;
  logic [15:0]            frac_r;
  logic signed [15:0]     target_r;
  logic signed [15:0]     env_r;
  // gain
  logic [27:0]            ww_r;
  logic [23:0]            rem_r;
  logic [16:0]            quo_r;
  logic [20:0]            gmag_r;
  logic [19:0]            l_r;
  logic [30:0]            g_r;
  logic [30:0]            lin_r;
  logic [SAMPLE_BITS-1:0] yl_r;
  logic [SAMPLE_BITS-1:0] lo_r, ro_r;
  logic [15:0]            gain_r;

  // load stage
  logic [SAMPLE_BITS-1:0] abs_l, abs_r, peak;
  logic [4:0]             lead;
  logic [31:0]            m0;

  always_comb begin
    abs_l = in_left[SAMPLE_BITS-1]  ? SAMPLE_BITS'(-in_left)  : SAMPLE_BITS'(in_left);
    abs_r = in_right[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_right) : SAMPLE_BITS'(in_right);
    peak  = (abs_l > abs_r) ? abs_l : abs_r;
    lead  = 5'd0;
    for (int k = 0; k < SAMPLE_BITS; k++) begin
      if (peak[k]) begin
        lead = 5'(k);
      end
    end
    m0 = 32'(peak) << (5'd31 - lead);
  end

  // shared multiplier operands
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [63:0]        prod;

  logic [20:0]        neg_lvl;
  logic signed [16:0] diff;
  logic [16:0]        dmag;
  logic [15:0]        coeff;
  logic signed [16:0] dgt;
  logic signed [18:0] d2, kn, wfull;
  logic [16:0]        ndm;
  logic [11:0]        slope;
  logic               knee_sel;

  always_comb begin
    neg_lvl  = {5'(SAMPLE_BITS - 1) - e_r, 16'd0} - {5'd0, frac_r};
    diff     = {env_r[15], env_r} - {target_r[15], target_r};
    dmag     = diff[16] ? 17'(-diff) : 17'(diff);
    coeff    = (target_r > env_r) ? cfg.attack_coeff : cfg.release_coeff;
    dgt      = {env_r[15], env_r} - {{2{cfg.threshold_db[14]}}, cfg.threshold_db};
    d2       = {dgt[16], dgt, 1'b0};
    kn       = {6'd0, cfg.knee_width_db};
    wfull    = kn - d2;
    ndm      = 17'(-dgt);
    slope    = (cfg.expansion_ratio < 12'd256) ? 12'd0 : cfg.expansion_ratio - 12'd256;
    knee_sel = (cfg.knee_width_db != 13'd0) && (d2 < kn) && (-d2 < kn);
  end

  assign stat.knee_sel = knee_sel;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      DP_LOG:   begin mul_a = m_r;                 mul_b = m_r;                   end
      DP_LEVEL: begin mul_a = 32'(neg_lvl);        mul_b = 32'(DB_PER_LOG2);      end
      DP_ENV:   begin mul_a = 32'(dmag);           mul_b = 32'(coeff);            end
      DP_GAIN: begin
        if (knee_sel) begin
          mul_a = 32'(wfull[13:0]);
          mul_b = 32'(wfull[13:0]);
        end else begin
          mul_a = 32'(slope);
          mul_b = 32'(ndm);
        end
      end
      DP_NUM:   begin mul_a = 32'(slope);          mul_b = 32'(ww_r);             end
      DP_L2:    begin mul_a = 32'(gmag_r[14:0]);   mul_b = 32'(LOG2_PER_DB);      end
      DP_EXP:   begin mul_a = 32'(g_r);            mul_b = c_tab[cmd.idx];        end
      DP_OUTL:  begin mul_a = 32'(al_r);           mul_b = 32'(lin_r);            end
      DP_OUTR:  begin mul_a = 32'(ar_r);           mul_b = 32'(lin_r);            end
      default:  begin mul_a = '0;                  mul_b = '0;                    end
    endcase
  end

  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  // post-multiply shaping
  logic [32:0]        sq;
  logic [40:0]        lvl_sum;
  logic [16:0]        lvl_mag;
  logic [33:0]        env_sum;
  logic [18:0]        env_rs;
  logic signed [18:0] env_new;
  logic [40:0]        nd;
  logic [24:0]        dtrial, den;
  logic               dge;
  logic [14:0]        fmag;
  logic [31:0]        shv;
  logic [3:0]         nsh;
  logic [63:0]        yprod;
  logic [SAMPLE_BITS-1:0] ymag;

  always_comb begin
    sq      = prod[63:31];
    lvl_sum = prod[40:0] + 41'd8388608;
    lvl_mag = lvl_sum[40:24];
    env_sum = prod[33:0] + 34'd32768;
    env_rs  = {1'b0, env_sum[33:16]};
    env_new = {{3{target_r[15]}}, target_r} + (diff[16] ? -$signed(env_rs) : $signed(env_rs));
    nd      = {1'b0, prod[39:0]} + {18'd0, cfg.knee_width_db, 10'd0};
    den     = {1'b0, cfg.knee_width_db, 11'd0};
    dtrial  = {rem_r, quo_r[16]};
    dge     = dtrial >= den;
    if (cfg.range_floor_db < -16'sd23040) begin
      fmag = 15'(GAIN_FLOOR_MAG);
    end else if (cfg.range_floor_db > 16'sd0) begin
      fmag = 15'd0;
    end else begin
      fmag = 15'(-cfg.range_floor_db);
    end
    nsh   = l_r[19:16];
    shv   = (nsh == 4'd0) ? 32'(g_r) : ((32'(g_r) >> (nsh - 4'd1)) + 32'd1) >> 1;
    yprod = prod + 64'd536870912;
    ymag  = yprod[SAMPLE_BITS+29:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r <= 16'sd0;
    end else if (cmd.op == DP_ENV) begin
      env_r <= env_new[15:0];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        l_neg_r   <= in_left[SAMPLE_BITS-1];
        r_neg_r   <= in_right[SAMPLE_BITS-1];
        al_r      <= abs_l;
        ar_r      <= abs_r;
        pk_zero_r <= (peak == '0);
        e_r       <= lead;
        m_r       <= m0;
        frac_r    <= 16'd0;
      end
      DP_LOG: begin
        m_r    <= sq[32] ? sq[32:1] : sq[31:0];
        frac_r <= {frac_r[14:0], sq[32]};
      end
      DP_LEVEL: begin
        if (pk_zero_r || lvl_mag >= 17'(LEVEL_FLOOR_MAG)) begin
          target_r <= -16'(LEVEL_FLOOR_MAG);
        end else begin
          target_r <= -$signed({1'b0, lvl_mag[14:0]});
        end
      end
      DP_GAIN: begin
        if (knee_sel) begin
          ww_r <= prod[27:0];
        end else if (dgt[16]) begin
          gmag_r <= 21'((prod[28:0] + 29'd128) >> 8);
        end else begin
          gmag_r <= 21'd0;
        end
      end
      DP_NUM: begin
        rem_r <= nd[40:17];
        quo_r <= nd[16:0];
      end
      DP_DIV: begin
        rem_r  <= dge ? 24'(dtrial - den) : dtrial[23:0];
        quo_r  <= {quo_r[15:0], dge};
        gmag_r <= {4'd0, quo_r[15:0], dge};
      end
      DP_CLAMP: begin
        if (gmag_r > 21'(fmag)) begin
          gmag_r <= 21'(fmag);
        end
      end
      DP_L2: begin
        l_r <= 20'((prod[36:0] + 37'd32768) >> 16);
        g_r <= 31'd1 << 30;
      end
      DP_EXP: begin
        if (l_r[cmd.idx]) begin
          g_r <= 31'((prod[60:0] + 61'd536870912) >> 30);
        end
      end
      DP_SHIFT: begin
        lin_r <= shv[30:0];
      end
      DP_OUTL: begin
        yl_r <= l_neg_r ? SAMPLE_BITS'(-ymag) : ymag;
      end
      DP_OUTR: begin
        lo_r   <= yl_r;
        ro_r   <= r_neg_r ? SAMPLE_BITS'(-ymag) : ymag;
        gain_r <= 16'(-gmag_r[15:0]);
      end
      default: ;
    endcase
  end

  assign left_out  = lo_r;
  assign right_out = ro_r;
  assign gain_db   = gain_r;

endmodule

// ----- hw/rtl/sldx_ctrl.sv -----
// Sequencer for the expander datapath: steps one pair through the phases; the divider phases run only inside the knee.
// Depends on sldx_pkg.
`timescale 1ns / 1ps
module sldx_ctrl
  import sldx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output logic     in_ready,
  output logic     out_valid,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = 5'd0;
        if (in_valid) state_nxt = ST_LOG;
      end
      ST_LOG: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(LOG_STEPS - 1)) begin
          state_nxt = ST_LEVEL;
          cnt_nxt   = 5'd0;
        end
      end
      ST_LEVEL: state_nxt = ST_ENV;
      ST_ENV:   state_nxt = ST_GAIN;
      ST_GAIN:  state_nxt = stat.knee_sel ? ST_NUM : ST_CLAMP;
      ST_NUM: begin
        state_nxt = ST_DIV;
        cnt_nxt   = 5'd0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = ST_CLAMP;
          cnt_nxt   = 5'd0;
        end
      end
      ST_CLAMP: state_nxt = ST_L2;
      ST_L2: begin
        state_nxt = ST_EXP;
        cnt_nxt   = 5'd0;
      end
      ST_EXP: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(EXP_STEPS - 1)) begin
          state_nxt = ST_SHIFT;
          cnt_nxt   = 5'd0;
        end
      end
      ST_SHIFT: state_nxt = ST_OUTL;
      ST_OUTL:  state_nxt = ST_OUTR;
      ST_OUTR: begin
        if (slot_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = DP_NOP;
    cmd.idx  = cnt_r[3:0];
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = DP_LOAD;
      end
      ST_LOG:   cmd.op = DP_LOG;
      ST_LEVEL: cmd.op = DP_LEVEL;
      ST_ENV:   cmd.op = DP_ENV;
      ST_GAIN:  cmd.op = DP_GAIN;
      ST_NUM:   cmd.op = DP_NUM;
      ST_DIV:   cmd.op = DP_DIV;
      ST_CLAMP: cmd.op = DP_CLAMP;
      ST_L2:    cmd.op = DP_L2;
      ST_EXP: begin
        cmd.op  = DP_EXP;
        cmd.idx = ~cnt_r[3:0];   // fraction bit 15 first
      end
      ST_SHIFT: cmd.op = DP_SHIFT;
      ST_OUTL:  cmd.op = DP_OUTL;
      ST_OUTR:  cmd.op = slot_free ? DP_OUTR : DP_NOP;
      default:  cmd.op = DP_NOP;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/stereo_linked_downward_expander.sv -----
// Top level of the stereo-linked soft-knee downward expander.
// Depends on sldx_pkg, sldx_in_if, sldx_out_if, sldx_ctrl and sldx_dp.
//
//   channel    direction  handshake                 request content
//   in_chan    sink       valid/ready               left_sample, right_sample
//   out_chan   source     valid/ready               left_out, right_out, gain_db
//   APB        slave      psel/penable, pready=1    six config registers at 4*i
//
// A pair takes longer from accept to result when the envelope sits inside the knee,
// where a 17-step restoring divider plus setup runs. The time is set by the
// one shared multiplier: 16 squaring steps for log2, 16 product steps for the
// exponent, and the single-ported sequencing of the remaining phases.
// rst_n is synchronous; it clears the sequencer, the output valid and the
// envelope (0 dB) and loads the register defaults. A stalled result sits in the
// output register; the next pair is accepted and processed meanwhile and only
// waits in its last phase until the slot frees.
`timescale 1ns / 1ps
module stereo_linked_downward_expander
  import sldx_pkg::*;
#(
  parameter int SAMPLE_BITS = SLDX_SAMPLE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  sldx_in_if.sink           in_chan,
  sldx_out_if.source        out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  reg_idx_t reg_idx;
  logic     wr_en;
  logic     in_ready, out_valid;

  // register file; a write lands at the access phase
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_db    <= THRESHOLD_RST;
      cfg_r.expansion_ratio <= RATIO_RST;
      cfg_r.attack_coeff    <= ATTACK_RST;
      cfg_r.release_coeff   <= RELEASE_RST;
      cfg_r.range_floor_db  <= FLOOR_RST;
      cfg_r.knee_width_db   <= KNEE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_THRESHOLD: cfg_r.threshold_db    <= pwdata[14:0];
        REG_RATIO:     cfg_r.expansion_ratio <= pwdata[11:0];
        REG_ATTACK:    cfg_r.attack_coeff    <= pwdata[15:0];
        REG_RELEASE:   cfg_r.release_coeff   <= pwdata[15:0];
        REG_FLOOR:     cfg_r.range_floor_db  <= pwdata[15:0];
        REG_KNEE:      cfg_r.knee_width_db   <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: prdata = {17'd0, cfg_r.threshold_db};
      REG_RATIO:     prdata = {20'd0, cfg_r.expansion_ratio};
      REG_ATTACK:    prdata = {16'd0, cfg_r.attack_coeff};
      REG_RELEASE:   prdata = {16'd0, cfg_r.release_coeff};
      REG_FLOOR:     prdata = {16'd0, cfg_r.range_floor_db};
      REG_KNEE:      prdata = {19'd0, cfg_r.knee_width_db};
      default:       prdata = '0;
    endcase
  end

  sldx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  sldx_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg       (cfg_r),
    .in_left   (in_chan.left_sample),
    .in_right  (in_chan.right_sample),
    .stat      (stat),
    .left_out  (out_chan.left_out),
    .right_out (out_chan.right_out),
    .gain_db   (out_chan.gain_db)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for stereo_linked_downward_expander: random and directed stereo pairs,
// a bit-exact predictor of level, envelope, expansion gain and output scaling, APB setup.
// Depends on sldx_pkg, sldx_in_if, sldx_out_if and the expander RTL.
`timescale 1ns / 1ps
module testbench;
  import sldx_pkg::*;

  localparam longint TIMEOUT_CYCLES = 3_000_000;
  localparam int     SETTLE_CYCLES  = 80;    // longer than the knee path

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } pair_t;

  typedef struct {
    logic [23:0] left;
    logic [23:0] right;
    logic [15:0] gain;
  } scaled_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  sldx_in_if  in_if ();
  sldx_out_if out_if ();

  stereo_linked_downward_expander u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the register file and of the envelope.
  longint thr_db, ratio_q8, attack_c, release_c, floor_db, knee_db;
  longint env_db;

  pair_t   pair_q[$];       // requests waiting for the driver
  scaled_t scaled_q[$];     // expected results in order
  int      err_count;
  int      mismatch_count;
  longint  cycle_count;
  bit      in_taken, out_taken;
  bit      calm;            // no idling on either side while set
  int      hold_left;       // long receiver hold-off, set by the stimulus
  int      send_gap, recv_stall;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned rnd_shift(longint unsigned v, int s);
    if (s == 0) return v;
    if (s >= 63) return 0;
    return (v + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Peak magnitude to dB Q8.8 via log2 with 16 fraction bits.
  function automatic longint peak_to_db(longint unsigned peak);
    int e;
    longint unsigned m, frac, neg;
    longint db;
    if (peak == 0) return -LEVEL_FLOOR_MAG;
    e = 0;
    while (e < 63 && (peak >> (e + 1)) != 0) e++;
    m = peak << (31 - e);
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    neg = longint'(SLDX_SAMPLE_BITS - 1 - e) * 65536 - frac;
    db = -longint'(rnd_shift(neg * DB_PER_LOG2, 24));
    if (db < -LEVEL_FLOOR_MAG) db = -LEVEL_FLOOR_MAG;
    return db;
  endfunction

  // Gain in dB Q8.8 (<= 0) to a Q2.30 linear factor.
  function automatic longint unsigned gain_to_lin(longint gdb);
    longint unsigned lg, n, f, g, c;
    lg = rnd_shift(longint'(-gdb) * LOG2_PER_DB, 16);
    n = lg >> 16;
    f = lg & 64'hFFFF;
    g = 64'd1 << 30;
    c = 64'd1 << 29;
    for (int i = 15; i >= 0; i--) begin
      c = int_sqrt(c << 30);
      if (f[i]) g = rnd_shift(g * c, 30);
    end
    if (n >= 40) return 0;
    return rnd_shift(g, int'(n));
  endfunction

  // Advances the envelope and returns the scaled pair.
  function automatic scaled_t expand_pair(pair_t p);
    scaled_t res;
    longint l, r, target, coeff, delta, d, gain, fl, slope, yl, yr;
    longint unsigned al, ar, peak, w, den, lin;
    l = p.left;
    r = p.right;
    al = (l < 0) ? -l : l;
    ar = (r < 0) ? -r : r;
    peak = (al > ar) ? al : ar;
    target = peak_to_db(peak);
    coeff = (target > env_db) ? attack_c : release_c;
    delta = coeff * (env_db - target);
    env_db = target + ((delta < 0) ? -longint'(rnd_shift(-delta, 16))
                                   : longint'(rnd_shift(delta, 16)));
    slope = ratio_q8 - 256;
    if (slope < 0) slope = 0;   // ratio below one: no expansion
    d = env_db - thr_db;
    if (knee_db > 0 && 2 * d < knee_db && -2 * d < knee_db) begin
      w = knee_db - 2 * d;
      den = 2048 * knee_db;
      gain = -longint'((slope * w * w + den / 2) / den);
    end else if (d < 0) begin
      gain = -longint'(rnd_shift(slope * (-d), 8));
    end else begin
      gain = 0;
    end
    fl = floor_db;
    if (fl < -GAIN_FLOOR_MAG) fl = -GAIN_FLOOR_MAG;
    if (fl > 0) fl = 0;
    if (gain < fl) gain = fl;
    lin = gain_to_lin(gain);
    yl = longint'(rnd_shift(al * lin, 30));
    yr = longint'(rnd_shift(ar * lin, 30));
    if (l < 0) yl = -yl;
    if (r < 0) yr = -yr;
    res.left  = yl[23:0];
    res.right = yr[23:0];
    res.gain  = gain[15:0];
    return res;
  endfunction

  // APB write: setup then access phase; model updated alongside.
  task automatic reg_write(reg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CFG_AW'(idx) << 2;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr_db    = longint'($signed(v[14:0]));
      REG_RATIO:     ratio_q8  = v[11:0];
      REG_ATTACK:    attack_c  = v[15:0];
      REG_RELEASE:   release_c = v[15:0];
      REG_FLOOR:     floor_db  = longint'($signed(v[15:0]));
      REG_KNEE:      knee_db   = v[12:0];
      default: ;
    endcase
  endtask

  task automatic write_all(int thr, int ratio, int att, int rel, int fl, int knee);
    reg_write(REG_THRESHOLD, thr);
    reg_write(REG_RATIO, ratio);
    reg_write(REG_ATTACK, att);
    reg_write(REG_RELEASE, rel);
    reg_write(REG_FLOOR, fl);
    reg_write(REG_KNEE, knee);
  endtask

  // Random sample spread over the whole level range, with occasional extremes.
  function automatic logic signed [23:0] rand_sample();
    logic [23:0] v;
    case ($urandom_range(0, 9))
      0: v = 24'h800000;
      1: v = 24'h7FFFFF;
      2: v = '0;
      3, 4: v = 24'($urandom);
      default: v = 24'($urandom >> $urandom_range(8, 31));
    endcase
    if (v != 24'h800000 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic queue_pair(logic signed [23:0] l, logic signed [23:0] r);
    pair_t p;
    p.left  = l;
    p.right = r;
    pair_q.push_back(p);
  endtask

  task automatic queue_random(int n);
    logic signed [23:0] a;
    for (int i = 0; i < n; i++) begin
      a = rand_sample();
      // linked channels are often close in level
      if ($urandom_range(0, 2) == 0) queue_pair(a, a >>> $urandom_range(0, 4));
      else queue_pair(a, rand_sample());
    end
  endtask

  // Sender pauses until every outstanding pair has come back and the block is idle.
  task automatic drain();
    while (pair_q.size() != 0 || scaled_q.size() != 0 || in_if.valid) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: presents pairs on the falling edge, random gap per request.
  always @(negedge clk) begin
    pair_t p;
    bit    took;
    took = in_taken;
    if (in_taken) begin
      in_taken = 1'b0;
      send_gap = calm ? 0 : $urandom_range(0, 12);
    end
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !took) begin
      // offer still pending
    end else if (send_gap > 0) begin
      send_gap--;
      in_if.valid <= 1'b0;
    end else if (pair_q.size() != 0) begin
      p = pair_q.pop_front();
      in_if.left_sample  <= p.left;
      in_if.right_sample <= p.right;
      in_if.valid        <= 1'b1;
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Acceptance of a request: predict its result.
  always @(posedge clk) begin
    pair_t p;
    if (rst_n && in_if.valid && in_if.ready) begin
      p.left  = in_if.left_sample;
      p.right = in_if.right_sample;
      scaled_q.push_back(expand_pair(p));
      in_taken = 1'b1;
    end
  end

  // Receiver readiness: per-result stall plus the occasional long hold-off.
  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      recv_stall = calm ? 0 : $urandom_range(0, 12);
    end
    if (hold_left > 0) hold_left--;
    else if (recv_stall > 0) recv_stall--;
    out_if.ready <= rst_n && hold_left == 0 && recv_stall == 0;
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    scaled_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      out_taken = 1'b1;
      if (scaled_q.size() == 0) begin
        err_count++;
        if (mismatch_count++ < 10)
          $display("unexpected result: L=%h R=%h G=%h", out_if.left_out, out_if.right_out,
                   out_if.gain_db);
      end else begin
        want = scaled_q.pop_front();
        if (out_if.left_out !== want.left || out_if.right_out !== want.right
            || out_if.gain_db !== want.gain) begin
          err_count++;
          if (mismatch_count++ < 10)
            $display("mismatch: exp L=%h R=%h G=%h got L=%h R=%h G=%h", want.left,
                     want.right, want.gain, out_if.left_out, out_if.right_out,
                     out_if.gain_db);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_if.valid = 1'b0; in_if.left_sample = '0; in_if.right_sample = '0;
    out_if.ready = 1'b0;
    err_count = 0; mismatch_count = 0; cycle_count = 0;
    in_taken = 1'b0; out_taken = 1'b0; calm = 1'b0;
    hold_left = 0; send_gap = 0; recv_stall = 0;
    thr_db = THRESHOLD_RST; ratio_q8 = RATIO_RST; attack_c = ATTACK_RST;
    release_c = RELEASE_RST; floor_db = FLOOR_RST; knee_db = KNEE_RST;
    env_db = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass under the reset settings: extremes, silence, very quiet peaks.
    queue_pair(24'sd0, 24'sd0);
    queue_pair(24'sh7FFFFF, -24'sh800000);
    queue_pair(-24'sh800000, -24'sh800000);
    queue_pair(24'sh7FFFFF, 24'sh7FFFFF);
    queue_pair(24'sd1, -24'sd1);
    queue_pair(24'sd0, 24'sd1);
    queue_pair(24'sd0, 24'sd0);
    queue_pair(24'sd300, -24'sd2000);
    queue_pair(24'sh004000, 24'sh000100);
    queue_pair(-24'sh020000, 24'sh001000);
    queue_pair(24'sh555555, -24'sh2AAAAA);
    queue_pair(24'sd0, -24'sh800000);
    drain();

    // Fast envelope, 24 dB knee and deepest floor.
    write_all(0, 2560, 0, 0, -23040, 6144);
    queue_random(8);
    queue_pair(24'sh000800, 24'sd0);
    queue_pair(24'sd7, -24'sd3);
    queue_pair(24'sd0, 24'sd0);
    drain();
    // Hard knee, slowest envelope, no attenuation allowed.
    write_all(-15360, 256, 65535, 65535, 0, 0);
    queue_random(150);
    drain();
    // Ratio below one, positive floor, widest knee, lowest threshold code.
    write_all(-16384, 0, 1000, 2000, 32767, 8191);
    queue_random(150);
    drain();
    // Largest ratio code, most negative floor code, receiver held off for a long stretch.
    write_all(16383, 4095, 30000, 50000, -32768, 1);
    hold_left = 600;
    queue_random(200);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      calm = ($urandom_range(0, 3) == 0);
      write_all($urandom_range(0, 15360) - 15360, $urandom_range(256, 2560),
                ($urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 20000)),
                ($urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 20000)),
                $urandom_range(0, 23040) - 23040,
                ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6144));
      queue_random(155);
      drain();
    end

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
